FILE: rtl/sfdl_pkg.sv
package sfdl_pkg;

    // Default sizing
    localparam int LINE_DEPTH  = 65536;
    localparam int SAMPLE_BITS = 24;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_DELAY_TARGET = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FEEDBACK     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIX          = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LP_GAIN      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LP_POLE      = 3'd4;

    // Register reset values
    localparam logic [31:0] DELAY_TARGET_RST = 32'd786432000;
    localparam logic [15:0] FEEDBACK_RST     = 16'd0;
    localparam logic [16:0] MIX_RST          = 17'd0;
    localparam logic [15:0] LP_GAIN_RST      = 16'd32768;
    localparam logic [15:0] LP_POLE_RST      = 16'd0;

    // Unity wet share, Q1.16
    localparam logic [16:0] MIX_UNITY = 17'h10000;

    // Delay glide: step = (diff * 66 + 0.5 lsb) >> 16
    localparam logic signed [39:0] GLIDE_RATE  = 40'sd66;
    localparam logic signed [39:0] GLIDE_ROUND = 40'sd32768;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_GLIDE,
        ST_REDUCE,
        ST_PTR,
        ST_RD0,
        ST_RD1,
        ST_MUL0,
        ST_MUL1,
        ST_SUM,
        ST_MUL2,
        ST_UPD,
        ST_WR,
        ST_DONE
    } t_state;

    // Coefficients shared by both channels
    typedef struct packed {
        logic [15:0] b0;    // low-pass feedforward, Q0.16
        logic [15:0] a1;    // low-pass pole, Q1.15 signed
        logic [15:0] fb;    // feedback gain, Q0.16
        logic [16:0] mix;   // wet share, clamped to unity
    } t_coef;

    // Stage strobes from the sequencer to a channel datapath
    typedef struct packed {
        logic ld_s0;
        logic interp;
        logic mix;
        logic sum;
        logic mul;
        logic upd;
    } t_chan_ctl;

    function automatic logic signed [63:0] sat_bits(input logic signed [63:0] v,
                                                    input int unsigned bits);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        hi = (64'sd1 <<< (bits - 1)) - 64'sd1;
        lo = -hi - 64'sd1;
        if (v > hi) begin
            return hi;
        end else if (v < lo) begin
            return lo;
        end
        return v;
    endfunction

endpackage

FILE: rtl/sfdl_line_mem.sv
module sfdl_line_mem #(
    parameter int DEPTH = 65536,
    parameter int WIDTH = 48
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/sfdl_channel.sv
module sfdl_channel #(
    parameter int SB = sfdl_pkg::SAMPLE_BITS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  sfdl_pkg::t_chan_ctl i_ctl,
    input  sfdl_pkg::t_coef     i_coef,
    input  logic [15:0]         i_frac,
    input  logic signed [SB-1:0] i_in,
    input  logic signed [SB-1:0] i_rdata,
    output logic signed [SB-1:0] o_out,
    output logic signed [SB-1:0] o_wdata
);

    logic signed [SB-1:0]  r_s0;
    logic signed [SB+17:0] r_pi;
    logic signed [SB+16:0] r_ffp;
    logic signed [SB+17:0] r_dry;
    logic signed [SB+17:0] r_wet;
    logic signed [SB:0]    r_ff;
    logic signed [SB-1:0]  r_y;
    logic signed [SB-1:0]  r_out;
    logic signed [SB+15:0] r_pole;
    logic signed [SB+16:0] r_fbp;
    logic signed [31:0]    r_fstate;
    logic signed [SB-1:0]  r_wdata;

    logic signed [SB:0]    diff;
    logic signed [SB+1:0]  rsum;
    logic signed [SB-1:0]  rval;
    logic [16:0]           dry_gain;
    logic signed [63:0]    ysum;
    logic signed [63:0]    osum;
    logic signed [63:0]    ssum;
    logic signed [63:0]    wsum;

    always_comb begin
        diff     = (SB+1)'(i_rdata) - (SB+1)'(r_s0);
        rsum     = (SB+2)'(r_s0) + (SB+2)'(r_pi >>> 16);
        rval     = $signed(rsum[SB-1:0]);
        dry_gain = sfdl_pkg::MIX_UNITY - i_coef.mix;
        // feedforward term straight from the product, r_ff is loaded on the same edge
        ysum     = (64'(r_ffp) >>> 16) + 64'(r_fstate);
        osum     = (64'(r_dry) + 64'(r_wet)) >>> 16;
        ssum     = 64'(r_ff) - 64'(r_pole >>> 15);
        wsum     = 64'(i_in) + 64'(r_fbp >>> 16);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld_s0) begin
            r_s0 <= i_rdata;
        end
        // s1 arrives straight from the memory read port
        if (i_ctl.interp) begin
            r_pi <= (SB+18)'(diff) * (SB+18)'($signed({1'b0, i_frac}));
        end
        if (i_ctl.mix) begin
            r_ffp <= (SB+17)'(rval) * (SB+17)'($signed({1'b0, i_coef.b0}));
            r_dry <= (SB+18)'(i_in) * (SB+18)'($signed({1'b0, dry_gain}));
            r_wet <= (SB+18)'(rval) * (SB+18)'($signed({1'b0, i_coef.mix}));
        end
        if (i_ctl.sum) begin
            r_ff  <= (SB+1)'(r_ffp >>> 16);
            r_y   <= SB'(sfdl_pkg::sat_bits(ysum, SB));
            r_out <= SB'(sfdl_pkg::sat_bits(osum, SB));
        end
        if (i_ctl.mul) begin
            r_pole <= (SB+16)'(r_y) * (SB+16)'($signed(i_coef.a1));
            r_fbp  <= (SB+17)'(r_y) * (SB+17)'($signed({1'b0, i_coef.fb}));
        end
        if (i_ctl.upd) begin
            r_wdata <= SB'(sfdl_pkg::sat_bits(wsum, SB));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fstate <= '0;
        end else if (i_ctl.upd) begin
            r_fstate <= 32'(sfdl_pkg::sat_bits(ssum, 32));
        end
    end

    assign o_out   = r_out;
    assign o_wdata = r_wdata;

endmodule

FILE: rtl/stereo_feedback_delay_line_top.sv
// Items: one at a time; the sequencer accepts a new item only after the result of the last one
//   is loaded into the output register. Outside bypass it reads each line twice through the
//   one read port of the line memory and writes it once per item; bypass touches no line.
// Reset: synchronous, active low; loads register defaults, clears filter states and the
//   write pointer. Lines read as zero until written (write-pointer fill tracking), so no
//   clearing pass.
module stereo_feedback_delay_line_top #(
    parameter int LINE_DEPTH  = sfdl_pkg::LINE_DEPTH,
    parameter int SAMPLE_BITS = sfdl_pkg::SAMPLE_BITS
) (
    input  logic i_clk,
    input  logic i_rst_n,

    // input stream; tdata: left_in, right_in (low bits up), zero pad to bytes
    input  logic                                  i_s_axis_tvalid,
    output logic                                  o_s_axis_tready,
    input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]    i_s_axis_tdata,

    // output stream; tdata: left_out, right_out (low bits up), zero pad to bytes
    output logic                                  o_m_axis_tvalid,
    input  logic                                  i_m_axis_tready,
    output logic [((2*SAMPLE_BITS+7)/8)*8-1:0]    o_m_axis_tdata,

    // configuration writes
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [sfdl_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [sfdl_pkg::CFG_DATA_W-1:0]       i_cfg_data
);

    localparam int SB      = SAMPLE_BITS;
    localparam int AW      = $clog2(LINE_DEPTH);
    localparam int TDATA_W = ((2*SB+7)/8)*8;
    // restoring steps to bring the 16-bit integer delay below the line length
    localparam int RED_STEPS = (LINE_DEPTH >= 65536) ? 1 : $clog2(65536 / LINE_DEPTH);

    sfdl_pkg::t_state r_state, n_state;

    // configuration registers
    logic [31:0] r_delay_target;
    logic [15:0] r_fb;
    logic [16:0] r_mix;
    logic [15:0] r_b0;
    logic [15:0] r_a1;

    // delay and pointer state
    logic [31:0]   r_smooth, n_smooth;
    logic [AW-1:0] r_dint, n_dint;
    logic [AW-1:0] r_i0, n_i0;
    logic [AW-1:0] r_i1, n_i1;
    logic [15:0]   r_frac, n_frac;
    logic [AW-1:0] r_wp, n_wp;
    logic          r_wrapped;
    logic          r_rd_valid;

    // item registers
    logic signed [SB-1:0] r_in_l, r_in_r;
    logic                 r_bypass;
    logic                 r_out_valid;
    logic signed [SB-1:0] r_o_l, r_o_r;

    // sequencer outputs
    logic                 accept;
    logic                 s_ready;
    logic                 mem_re;
    logic                 mem_we;
    logic [AW-1:0]        mem_raddr;
    logic                 out_load;
    sfdl_pkg::t_chan_ctl  ctl;
    sfdl_pkg::t_coef      coef;

    logic [2*SB-1:0]      rdata;
    logic [2*SB-1:0]      rdata_m;
    logic signed [SB-1:0] out_l, out_r;
    logic signed [SB-1:0] wdata_l, wdata_r;

    logic signed [32:0]   glide_diff;
    logic signed [39:0]   glide_step;
    logic [15:0]          red_v;
    logic [AW:0]          pos_raw;
    logic [AW:0]          pos_adj;

    assign accept = i_s_axis_tvalid && s_ready;

    // ---------------- sequencer: next state ----------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sfdl_pkg::ST_IDLE: begin
                if (accept) begin
                    // mix of zero passes the frame through untouched
                    n_state = (r_mix == '0) ? sfdl_pkg::ST_DONE : sfdl_pkg::ST_GLIDE;
                end
            end
            sfdl_pkg::ST_GLIDE:  n_state = sfdl_pkg::ST_REDUCE;
            sfdl_pkg::ST_REDUCE: n_state = sfdl_pkg::ST_PTR;
            sfdl_pkg::ST_PTR:    n_state = sfdl_pkg::ST_RD0;
            sfdl_pkg::ST_RD0:    n_state = sfdl_pkg::ST_RD1;
            sfdl_pkg::ST_RD1:    n_state = sfdl_pkg::ST_MUL0;
            sfdl_pkg::ST_MUL0:   n_state = sfdl_pkg::ST_MUL1;
            sfdl_pkg::ST_MUL1:   n_state = sfdl_pkg::ST_SUM;
            sfdl_pkg::ST_SUM:    n_state = sfdl_pkg::ST_MUL2;
            sfdl_pkg::ST_MUL2:   n_state = sfdl_pkg::ST_UPD;
            sfdl_pkg::ST_UPD:    n_state = sfdl_pkg::ST_WR;
            sfdl_pkg::ST_WR:     n_state = sfdl_pkg::ST_DONE;
            sfdl_pkg::ST_DONE: begin
                // hold until the output register frees up
                if (!r_out_valid || i_m_axis_tready) begin
                    n_state = sfdl_pkg::ST_IDLE;
                end
            end
            default: n_state = sfdl_pkg::ST_IDLE;
        endcase
    end

    // ---------------- sequencer: outputs ----------------
    always_comb begin
        s_ready   = 1'b0;
        mem_re    = 1'b0;
        mem_we    = 1'b0;
        mem_raddr = r_i0;
        out_load  = 1'b0;
        ctl       = '0;
        unique case (r_state)
            sfdl_pkg::ST_IDLE: s_ready = 1'b1;
            sfdl_pkg::ST_RD0: begin
                mem_re    = 1'b1;
                mem_raddr = r_i0;
            end
            sfdl_pkg::ST_RD1: begin
                // i0 data is on the read port now; issue i1
                mem_re    = 1'b1;
                mem_raddr = r_i1;
                ctl.ld_s0 = 1'b1;
            end
            sfdl_pkg::ST_MUL0: ctl.interp = 1'b1;
            sfdl_pkg::ST_MUL1: ctl.mix    = 1'b1;
            sfdl_pkg::ST_SUM:  ctl.sum    = 1'b1;
            sfdl_pkg::ST_MUL2: ctl.mul    = 1'b1;
            sfdl_pkg::ST_UPD:  ctl.upd    = 1'b1;
            sfdl_pkg::ST_WR:   mem_we     = 1'b1;
            sfdl_pkg::ST_DONE: out_load   = !r_out_valid || i_m_axis_tready;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sfdl_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // ---------------- configuration ----------------
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay_target <= sfdl_pkg::DELAY_TARGET_RST;
            r_fb           <= sfdl_pkg::FEEDBACK_RST;
            r_mix          <= sfdl_pkg::MIX_RST;
            r_b0           <= sfdl_pkg::LP_GAIN_RST;
            r_a1           <= sfdl_pkg::LP_POLE_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                sfdl_pkg::CFG_DELAY_TARGET: r_delay_target <= i_cfg_data;
                sfdl_pkg::CFG_FEEDBACK:     r_fb           <= i_cfg_data[15:0];
                sfdl_pkg::CFG_MIX:          r_mix          <= i_cfg_data[16:0];
                sfdl_pkg::CFG_LP_GAIN:      r_b0           <= i_cfg_data[15:0];
                sfdl_pkg::CFG_LP_POLE:      r_a1           <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        coef.b0  = r_b0;
        coef.a1  = r_a1;
        coef.fb  = r_fb;
        // anything above unity counts as unity
        coef.mix = r_mix[16] ? sfdl_pkg::MIX_UNITY : r_mix;
    end

    // ---------------- delay glide and read address ----------------
    always_comb begin
        glide_diff = $signed({1'b0, r_delay_target}) - $signed({1'b0, r_smooth});
        glide_step = 40'(glide_diff) * sfdl_pkg::GLIDE_RATE + sfdl_pkg::GLIDE_ROUND;
        n_smooth   = r_smooth + 32'(glide_step >>> 16);
    end

    // integer delay modulo line length, a few restoring compare-subtract steps
    always_comb begin
        red_v = r_smooth[31:16];
        for (int k = RED_STEPS - 1; k >= 0; k--) begin
            if ({16'b0, red_v} >= (32'(LINE_DEPTH) << k)) begin
                red_v = red_v - 16'(32'(LINE_DEPTH) << k);
            end
        end
        n_dint = AW'(red_v);
    end

    // position = wp - delay, with the fractional part borrowing one sample
    always_comb begin
        pos_raw = {1'b0, r_wp} + (AW+1)'(LINE_DEPTH) - {1'b0, r_dint}
                  - (AW+1)'(r_smooth[15:0] != 16'd0);
        pos_adj = (pos_raw >= (AW+1)'(LINE_DEPTH)) ? pos_raw - (AW+1)'(LINE_DEPTH)
                                                   : pos_raw;
        n_i0    = AW'(pos_adj);
        n_i1    = (n_i0 == AW'(LINE_DEPTH - 1)) ? '0 : n_i0 + 1'b1;
        n_frac  = ~r_smooth[15:0] + 16'd1;
        n_wp    = (r_wp == AW'(LINE_DEPTH - 1)) ? '0 : r_wp + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_smooth  <= sfdl_pkg::DELAY_TARGET_RST;
            r_wp      <= '0;
            r_wrapped <= 1'b0;
        end else begin
            if (r_state == sfdl_pkg::ST_GLIDE) begin
                r_smooth <= n_smooth;
            end
            if (mem_we) begin
                r_wp <= n_wp;
                if (r_wp == AW'(LINE_DEPTH - 1)) begin
                    r_wrapped <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == sfdl_pkg::ST_REDUCE) begin
            r_dint <= n_dint;
        end
        if (r_state == sfdl_pkg::ST_PTR) begin
            r_i0   <= n_i0;
            r_i1   <= n_i1;
            r_frac <= n_frac;
        end
        // entries at or past the write pointer before the first wrap were never written
        if (mem_re) begin
            r_rd_valid <= r_wrapped || (mem_raddr < r_wp);
        end
        if (accept) begin
            r_in_l   <= $signed(i_s_axis_tdata[SB-1:0]);
            r_in_r   <= $signed(i_s_axis_tdata[2*SB-1:SB]);
            r_bypass <= (r_mix == '0);
        end
        if (out_load) begin
            r_o_l <= r_bypass ? r_in_l : out_l;
            r_o_r <= r_bypass ? r_in_r : out_r;
        end
    end

    // ---------------- line memory: {right, left} per entry ----------------
    sfdl_line_mem #(
        .DEPTH (LINE_DEPTH),
        .WIDTH (2*SB)
    ) u_line_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_wp),
        .i_wdata ({wdata_r, wdata_l}),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (rdata)
    );

    assign rdata_m = r_rd_valid ? rdata : '0;

    // ---------------- channel datapaths ----------------
    sfdl_channel #(
        .SB (SB)
    ) u_chan_l (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl),
        .i_coef  (coef),
        .i_frac  (r_frac),
        .i_in    (r_in_l),
        .i_rdata ($signed(rdata_m[SB-1:0])),
        .o_out   (out_l),
        .o_wdata (wdata_l)
    );

    sfdl_channel #(
        .SB (SB)
    ) u_chan_r (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl),
        .i_coef  (coef),
        .i_frac  (r_frac),
        .i_in    (r_in_r),
        .i_rdata ($signed(rdata_m[2*SB-1:SB])),
        .o_out   (out_r),
        .o_wdata (wdata_r)
    );

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_s_axis_tready = s_ready;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = TDATA_W'({r_o_r, r_o_l});

endmodule

FILE: rtl/sfdl_checker.sv
module sfdl_checker #(
    parameter int SAMPLE_BITS = 24
) (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 i_s_axis_tvalid,
    input logic                                 o_s_axis_tready,
    input logic                                 o_m_axis_tvalid,
    input logic                                 i_m_axis_tready,
    input logic [((2*SAMPLE_BITS+7)/8)*8-1:0]   o_m_axis_tdata,
    input logic                                 o_cfg_ready
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("output item changed while stalled");

    // reset empties the output register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");

    // one item in flight: no accept right after an accept
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("input accepted while an item is in flight");

    // a new result is only loaded while the input side is busy
    a_load_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> $past(!o_s_axis_tready))
        else $error("result loaded while idle");

    // configuration never back-pressures
    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cfg_ready)
        else $error("configuration port not ready");

endmodule

bind stereo_feedback_delay_line_top sfdl_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_sfdl_checker (.*);

FILE: verif/tb_stereo_feedback_delay_line_top.sv
`timescale 1ns / 100ps

module tb_stereo_feedback_delay_line_top;

    localparam int SB    = sfdl_pkg::SAMPLE_BITS;
    localparam int DEPTH = sfdl_pkg::LINE_DEPTH;
    localparam int TD_W  = ((2*SB+7)/8)*8;

    localparam int LIMIT_CYCLES    = 1_000_000;
    localparam int DRAIN_CYCLES    = 16;
    localparam int LONG_HOLD       = 300;     // long output stall, cycles
    localparam int GLIDE_IN_FRAMES = 400;
    localparam int RAND_PHASES     = 8;
    localparam int PHASE_FRAMES    = 48;
    localparam int PRESSURE_PHASE  = 3;

    // no register lives here; the block must ignore writes to it
    localparam logic [sfdl_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

    localparam longint S_MAX      = (64'sd1 <<< (SB-1)) - 64'sd1;
    localparam longint S_MIN      = -S_MAX - 64'sd1;
    localparam longint W_MAX      = 64'sd2147483647;
    localparam longint W_MIN      = -W_MAX - 64'sd1;
    localparam longint Q16_ONE    = 64'sd65536;
    localparam longint GLIDE_NUM  = 64'sd66;
    localparam longint GLIDE_HALF = 64'sd32768;

    typedef logic signed [SB-1:0] t_sample;
    typedef struct packed {
        t_sample right;
        t_sample left;
    } t_frame;

    // ---------------------------------------------------------------- DUT
    logic                                i_clk           = 1'b0;
    logic                                i_rst_n         = 1'b0;
    logic                                i_s_axis_tvalid = 1'b0;
    logic                                o_s_axis_tready;
    logic [TD_W-1:0]                     i_s_axis_tdata  = '0;
    logic                                o_m_axis_tvalid;
    logic                                i_m_axis_tready = 1'b0;
    logic [TD_W-1:0]                     o_m_axis_tdata;
    logic                                i_cfg_valid     = 1'b0;
    logic                                o_cfg_ready;
    logic [sfdl_pkg::CFG_IDX_W-1:0]      i_cfg_index     = '0;
    logic [sfdl_pkg::CFG_DATA_W-1:0]     i_cfg_data      = '0;

    stereo_feedback_delay_line_top i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // ---------------------------------------------------------- predictor
    // Register mirrors, loaded on accepted config writes.
    logic [31:0]        p_target = sfdl_pkg::DELAY_TARGET_RST;
    logic [15:0]        p_fb     = sfdl_pkg::FEEDBACK_RST;
    logic [16:0]        p_mix    = sfdl_pkg::MIX_RST;
    logic [15:0]        p_b0     = sfdl_pkg::LP_GAIN_RST;
    logic signed [15:0] p_a1     = sfdl_pkg::LP_POLE_RST;

    // Block state mirror.
    logic [31:0] glide_pos = sfdl_pkg::DELAY_TARGET_RST;   // smoothed delay, 16.16
    int unsigned wr_ptr    = 0;
    longint      lp_state [2];
    t_sample     delay_mem [2][DEPTH];

    t_frame frame_in_q [$];      // items waiting to be offered
    t_frame mixed_out_q [$];     // predicted output frames, oldest first

    int frames_in     = 0;
    int results_ok    = 0;
    int bypass_frames = 0;
    int echo_reads    = 0;
    int cfg_writes    = 0;
    int fails         = 0;
    int cycle_cnt     = 0;

    // idle/stall knobs, written by the stimulus process at negedge
    int src_max_gap   = 0;
    int snk_max_gap   = 0;
    int long_hold_req = 0;

    function automatic longint clip(input longint v, input longint lo, input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // One channel: interpolated read, low-pass, line write, dry/wet mix.
    function automatic longint channel_out(input int ch, input longint x, input longint m);
        longint total, pos, i0, i1, frac, s0, s1, rd, ff, y, st;
        total = longint'(DEPTH) <<< 16;
        pos   = (longint'(wr_ptr) <<< 16) + total - (longint'(glide_pos) % total);
        if (pos >= total) begin
            pos = pos - total;
        end
        i0   = pos >>> 16;
        frac = pos & 64'sd65535;
        i1   = (i0 + 1) % DEPTH;
        s0   = delay_mem[ch][i0];
        s1   = delay_mem[ch][i1];
        rd   = s0 + (((s1 - s0) * frac) >>> 16);
        if (rd != 0) begin
            echo_reads++;
        end
        // transposed direct form, b0 == b1
        ff = (rd * longint'(p_b0)) >>> 16;
        y  = clip(ff + lp_state[ch], S_MIN, S_MAX);
        st = ff - ((longint'(p_a1) * y) >>> 15);
        lp_state[ch] = clip(st, W_MIN, W_MAX);
        delay_mem[ch][wr_ptr] = t_sample'(clip(x + ((y * longint'(p_fb)) >>> 16),
                                               S_MIN, S_MAX));
        return clip((x * (Q16_ONE - m) + rd * m) >>> 16, S_MIN, S_MAX);
    endfunction

    function automatic void compute_mixed_frame(input t_frame x, output t_frame y);
        longint m, d;
        if (p_mix == '0) begin
            // bypass: pass through, state frozen
            y = x;
            bypass_frames++;
            return;
        end
        m = (p_mix > 17'd65536) ? Q16_ONE : longint'(p_mix);
        d = longint'(p_target) - longint'(glide_pos);
        glide_pos = 32'(longint'(glide_pos) + ((d * GLIDE_NUM + GLIDE_HALF) >>> 16));
        y.left  = t_sample'(channel_out(0, longint'(x.left), m));
        y.right = t_sample'(channel_out(1, longint'(x.right), m));
        wr_ptr  = (wr_ptr + 1) % DEPTH;
    endfunction

    // ------------------------------------------------------------- driver
    int src_gap = 0;

    always @(posedge i_clk) begin : drv
        t_frame x, y;
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
            i_s_axis_tdata  <= '0;
            src_gap = 0;
        end else begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                x = i_s_axis_tdata[2*SB-1:0];
                compute_mixed_frame(x, y);
                mixed_out_q.push_back(y);
                frames_in++;
            end
            // slot is free unless an offered item is still waiting
            if (!i_s_axis_tvalid || o_s_axis_tready) begin
                if (src_gap > 0) begin
                    src_gap = src_gap - 1;
                    i_s_axis_tvalid <= 1'b0;
                end else if (frame_in_q.size() != 0) begin
                    x = frame_in_q.pop_front();
                    i_s_axis_tdata  <= TD_W'(x);
                    i_s_axis_tvalid <= 1'b1;
                    src_gap = $urandom_range(0, src_max_gap);
                end else begin
                    i_s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // ----------------------------------------------------- monitor / sink
    int snk_wait  = 0;
    int hold_seen = 0;
    int hold_left = 0;

    always @(posedge i_clk) begin : mon
        t_frame got, want;
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
            snk_wait = 0;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                got = o_m_axis_tdata[2*SB-1:0];
                if (mixed_out_q.size() == 0) begin
                    $error("unexpected output item: left_out %0d, right_out %0d",
                           got.left, got.right);
                    fails++;
                end else begin
                    want = mixed_out_q.pop_front();
                    if (got.left !== want.left) begin
                        $error("left_out: expected %0d, got %0d", want.left, got.left);
                        fails++;
                    end
                    if (got.right !== want.right) begin
                        $error("right_out: expected %0d, got %0d", want.right, got.right);
                        fails++;
                    end
                    results_ok++;
                end
                snk_wait = $urandom_range(0, snk_max_gap);
            end
            if (hold_seen != long_hold_req) begin
                hold_seen = long_hold_req;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left = hold_left - 1;
                i_m_axis_tready <= 1'b0;
            end else if (snk_wait > 0) begin
                snk_wait = snk_wait - 1;
                i_m_axis_tready <= 1'b0;
            end else begin
                i_m_axis_tready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------ timeout
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= LIMIT_CYCLES) begin
            $error("timed out after %0d cycles, %0d results outstanding",
                   cycle_cnt, mixed_out_q.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // ----------------------------------------------------------- stimulus
    task automatic write_reg(input logic [sfdl_pkg::CFG_IDX_W-1:0] idx,
                             input logic [31:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            sfdl_pkg::CFG_DELAY_TARGET: p_target = val;
            sfdl_pkg::CFG_FEEDBACK:     p_fb     = val[15:0];
            sfdl_pkg::CFG_MIX:          p_mix    = val[16:0];
            sfdl_pkg::CFG_LP_GAIN:      p_b0     = val[15:0];
            sfdl_pkg::CFG_LP_POLE:      p_a1     = val[15:0];
            default: ;
        endcase
        cfg_writes++;
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    // block idle: nothing queued, nothing offered, nothing outstanding
    task automatic wait_idle();
        while (frame_in_q.size() != 0 || i_s_axis_tvalid || mixed_out_q.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic push_pair(input longint l, input longint r);
        t_frame f;
        f.left  = t_sample'(l);
        f.right = t_sample'(r);
        frame_in_q.push_back(f);
    endtask

    task automatic queue_random_frames(input int n);
        t_sample s [2];
        t_frame  f;
        repeat (n) begin
            for (int c = 0; c < 2; c++) begin
                case ($urandom_range(0, 9))
                    0:       s[c] = t_sample'(S_MAX);
                    1:       s[c] = t_sample'(S_MIN);
                    2:       s[c] = t_sample'(int'($urandom_range(0, 32)) - 16);
                    default: s[c] = t_sample'($urandom());
                endcase
            end
            f.left  = s[0];
            f.right = s[1];
            frame_in_q.push_back(f);
        end
    endtask

    // Random register set. Upper data bits beyond each register are noise.
    task automatic apply_random_settings(input bit full_target);
        logic [31:0] v;
        // keep the delay short unless asked, so reads stay on written data
        v = full_target ? $urandom() : $urandom_range(0, 600*65536);
        write_reg(sfdl_pkg::CFG_DELAY_TARGET, v);
        case ($urandom_range(0, 3))
            0:       v = 32'd0;
            1:       v = 32'd55705;
            2:       v = 32'd65535;
            default: v = $urandom_range(0, 65535);
        endcase
        write_reg(sfdl_pkg::CFG_FEEDBACK, v | ($urandom() & 32'hFFFF_0000));
        case ($urandom_range(0, 5))
            0:       v = 32'd0;
            1:       v = 32'd65536;
            2:       v = $urandom_range(65537, 131071);
            default: v = $urandom_range(1, 65535);
        endcase
        write_reg(sfdl_pkg::CFG_MIX, v | ($urandom() & 32'hFFFE_0000));
        case ($urandom_range(0, 3))
            0:       v = 32'd0;
            1:       v = 32'd65535;
            default: v = $urandom_range(0, 65535);
        endcase
        write_reg(sfdl_pkg::CFG_LP_GAIN, v | ($urandom() & 32'hFFFF_0000));
        case ($urandom_range(0, 3))
            0:       v = 32'h0000_8000;
            1:       v = 32'h0000_7FFF;
            default: v = $urandom_range(0, 65535);
        endcase
        write_reg(sfdl_pkg::CFG_LP_POLE, v | ($urandom() & 32'hFFFF_0000));
    endtask

    initial begin : stim
        for (int c = 0; c < 2; c++) begin
            lp_state[c] = 0;
            for (int k = 0; k < DEPTH; k++) begin
                delay_mem[c][k] = '0;
            end
        end
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Out of reset mix is zero: bypass, sample extremes straight through.
        src_max_gap = 2;
        snk_max_gap = 2;
        push_pair(S_MAX, S_MIN);
        push_pair(S_MIN, S_MAX);
        push_pair(0, -1);
        push_pair(-1, 0);
        wait_idle();

        // Top of every range: mix above unity, feedback past 0.85,
        // unstable pole, target at the top of the 32-bit delay.
        write_reg(sfdl_pkg::CFG_DELAY_TARGET, 32'hFFFF_FFFF);
        write_reg(sfdl_pkg::CFG_FEEDBACK, 32'd65535);
        write_reg(sfdl_pkg::CFG_MIX, 32'd131071);
        write_reg(sfdl_pkg::CFG_LP_GAIN, 32'd65535);
        write_reg(sfdl_pkg::CFG_LP_POLE, 32'h0000_8000);
        push_pair(S_MAX, S_MAX);
        push_pair(S_MIN, S_MIN);
        push_pair(S_MAX, S_MIN);
        push_pair(1, -1);
        push_pair(0, 0);
        wait_idle();

        // Bottom of the ranges, smallest non-bypass mix.
        write_reg(sfdl_pkg::CFG_DELAY_TARGET, 32'd0);
        write_reg(sfdl_pkg::CFG_FEEDBACK, 32'd0);
        write_reg(sfdl_pkg::CFG_MIX, 32'd1);
        write_reg(sfdl_pkg::CFG_LP_GAIN, 32'd0);
        write_reg(sfdl_pkg::CFG_LP_POLE, 32'h0000_7FFF);
        push_pair(S_MAX, S_MIN);
        push_pair(S_MIN, S_MAX);
        push_pair(-1, 1);
        push_pair(S_MIN, S_MIN);
        wait_idle();

        // Write to an empty index must change nothing; then nominal limits.
        write_reg(CFG_UNUSED, 32'hFFFF_FFFF);
        write_reg(sfdl_pkg::CFG_DELAY_TARGET, 32'd65536);
        write_reg(sfdl_pkg::CFG_FEEDBACK, 32'd55705);
        write_reg(sfdl_pkg::CFG_MIX, 32'd65536);
        write_reg(sfdl_pkg::CFG_LP_GAIN, 32'd32768);
        write_reg(sfdl_pkg::CFG_LP_POLE, 32'd0);
        push_pair(S_MAX, S_MAX);
        push_pair(12345, -12345);
        push_pair(S_MIN, 0);
        push_pair(0, S_MAX);
        wait_idle();

        // Glide-in: the delay starts near 12000 samples and only moves ~0.1%
        // per frame, so most reads here land on entries not yet written and
        // must come back as zero while the glide and the filter keep running.
        write_reg(sfdl_pkg::CFG_DELAY_TARGET, 32'(37*65536 + 32768));
        write_reg(sfdl_pkg::CFG_FEEDBACK, 32'd50000);
        write_reg(sfdl_pkg::CFG_MIX, 32'd40000);
        write_reg(sfdl_pkg::CFG_LP_GAIN, 32'd40000);
        write_reg(sfdl_pkg::CFG_LP_POLE, 32'(-12000));
        for (int k = 0; k < 4; k++) begin
            src_max_gap = $urandom_range(0, 1) ? 16 : 0;
            snk_max_gap = $urandom_range(0, 1) ? 16 : 0;
            queue_random_frames(GLIDE_IN_FRAMES / 4);
            while (frame_in_q.size() != 0) begin
                @(negedge i_clk);
            end
        end
        wait_idle();

        // Random phases, fresh register set each time. The last one lets the
        // target go anywhere, since that drags the delay off the written data.
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            apply_random_settings(ph == RAND_PHASES - 1);
            if (ph == PRESSURE_PHASE) begin
                // sender keeps offering while the output is held off
                src_max_gap = 0;
                snk_max_gap = 4;
                long_hold_req++;
            end else begin
                src_max_gap = $urandom_range(0, 1) ? 16 : 0;
                snk_max_gap = $urandom_range(0, 1) ? 16 : 0;
            end
            queue_random_frames(PHASE_FRAMES);
            wait_idle();
        end

        $display("covered %0d frames (%0d in bypass), %0d register writes, %0d results checked",
                 frames_in, bypass_frames, cfg_writes, results_ok);
        $display("echo path: %0d channel reads hit line data; delay ended at %0d/65536 samples",
                 echo_reads, glide_pos);
        if (fails == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
